[rtl/core/ricart_agrawala_mutex_node_defines.svh]
// Assertion macros shared by the mutual exclusion node RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef RICART_AGRAWALA_MUTEX_NODE_DEFINES_SVH
`define RICART_AGRAWALA_MUTEX_NODE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property must hold at every edge outside reset
`define RAMUTEX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen outside reset
`define RAMUTEX_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RAMUTEX_ASSERT(lbl, prop, msg)
`define RAMUTEX_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/core/ramutex_pkg.sv]
// Package for the mutual exclusion node: widths, codes, FSM states and
// the command/status structs between controller and datapath. No dependencies.
package ramutex_pkg;

  localparam int NODES      = 16;
  localparam int SEQ_BITS   = 16;
  localparam int ID_W       = 4;
  localparam int CNT_W      = 5;
  localparam int OP_W       = 2;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int MASK_W     = 16;
  localparam int TOP_NODES  = (NODES < 16) ? NODES : 16;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_ID    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(TOP_NODES);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_OWN_REQ  = 2'd0,
    OP_OWN_REL  = 2'd1,
    OP_PEER_REQ = 2'd2,
    OP_PEER_REP = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    MSG_REQUEST = 2'd0,
    MSG_REPLY   = 2'd1,
    MSG_GRANT   = 2'd2
  } msg_kind_t;

  typedef enum logic [1:0] {
    DEST_IDX,
    DEST_PEER,
    DEST_SELF
  } dest_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_BCAST,
    S_RELEASE,
    S_REPLY,
    S_GRANT
  } state_t;

  typedef struct packed {
    logic      cap_in;
    logic      start_req;
    logic      start_rel;
    logic      upd_high;
    logic      set_defer;
    logic      dec_reply;
    logic      idx_inc;
    logic      clr_bit;
    logic      emit;
    msg_kind_t emit_kind;
    dest_sel_t emit_dest;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic req_idle;
    logic rel_ok;
    logic mask_any;
    logic peer_ok;
    logic defer;
    logic reply_ok;
    logic reply_final;
    logic slot_free;
    logic idx_is_self;
    logic idx_last_peer;
    logic idx_bit;
    logic mask_last;
  } sts_t;

endpackage

[rtl/core/ramutex_ifs.sv]
// Handshake channel interfaces: input events, result messages, register writes.
// Depends on ramutex_pkg for field widths.
interface ramutex_in_if import ramutex_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [ID_W-1:0]     peer_id;
  logic [SEQ_BITS-1:0] sequence_req;
  modport source (output valid, operation, peer_id, sequence_req, input ready);
  modport sink (input valid, operation, peer_id, sequence_req, output ready);
endinterface

interface ramutex_out_if import ramutex_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   message_kind;
  logic [ID_W-1:0]     dest_node;
  logic [SEQ_BITS-1:0] sequence_out;
  logic                last;
  modport source (output valid, message_kind, dest_node, sequence_out, last, input ready);
  modport sink (input valid, message_kind, dest_node, sequence_out, last, output ready);
endinterface

interface ramutex_cfg_if import ramutex_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/ramutex_dp.sv]
// Datapath: configuration, protocol state, captured event, peer scan index
// and the output message register. Depends on ramutex_pkg.
module ramutex_dp import ramutex_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [ID_W-1:0]       in_peer_id,
  input  logic [SEQ_BITS-1:0]   in_sequence_req,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [KIND_W-1:0]     out_message_kind,
  output logic [ID_W-1:0]       out_dest_node,
  output logic [SEQ_BITS-1:0]   out_sequence_out,
  output logic                  out_last,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  logic [ID_W-1:0]     node_id_r;
  logic [CNT_W-1:0]    node_count_r;
  logic                requesting_r;
  logic [ID_W-1:0]     replies_r;
  logic [SEQ_BITS-1:0] highest_r;
  logic [SEQ_BITS-1:0] own_r;
  logic [MASK_W-1:0]   deferred_r;
  logic [ID_W-1:0]     idx_r;
  op_t                 op_r;
  logic [ID_W-1:0]     peer_r;
  logic [SEQ_BITS-1:0] seq_r;
  logic                out_valid_r;
  logic [KIND_W-1:0]   kind_r;
  logic [ID_W-1:0]     dest_r;
  logic [SEQ_BITS-1:0] seqo_r;
  logic                last_r;

  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    node_id_ext;
  logic [CNT_W-1:0]    last_peer;
  logic [CNT_W-1:0]    n_peers;
  logic [MASK_W-1:0]   idx_onehot;
  logic [MASK_W-1:0]   peer_onehot;
  logic [SEQ_BITS-1:0] own_nxt;
  logic [ID_W-1:0]     dest_nxt;

  always_comb begin
    if (node_count_r < CNT_MIN) begin
      cnt = CNT_MIN;
    end else if (node_count_r > CNT_MAX) begin
      cnt = CNT_MAX;
    end else begin
      cnt = node_count_r;
    end
    node_id_ext = {1'b0, node_id_r};
    last_peer   = (node_id_ext == cnt - CNT_W'(1)) ? cnt - CNT_W'(2) : cnt - CNT_W'(1);
    n_peers     = (node_id_ext < cnt) ? cnt - CNT_W'(1) : cnt;
    idx_onehot  = {{(MASK_W-1){1'b0}}, 1'b1} << idx_r;
    peer_onehot = {{(MASK_W-1){1'b0}}, 1'b1} << peer_r;
    own_nxt     = (highest_r == {SEQ_BITS{1'b1}}) ? highest_r : highest_r + SEQ_BITS'(1);
    unique case (cmd.emit_dest)
      DEST_PEER: dest_nxt = peer_r;
      DEST_SELF: dest_nxt = node_id_r;
      default:   dest_nxt = idx_r;
    endcase
  end

  always_comb begin
    sts.op            = op_r;
    sts.req_idle      = !requesting_r;
    sts.rel_ok        = requesting_r && (replies_r == '0);
    sts.mask_any      = (deferred_r != '0);
    sts.peer_ok       = (peer_r != node_id_r) && ({1'b0, peer_r} < cnt);
    sts.defer         = requesting_r &&
                        ((seq_r > own_r) || ((seq_r == own_r) && (peer_r > node_id_r)));
    sts.reply_ok      = sts.peer_ok && requesting_r && (replies_r != '0);
    sts.reply_final   = (replies_r == ID_W'(1));
    sts.slot_free     = !out_valid_r || out_ready;
    sts.idx_is_self   = (idx_r == node_id_r);
    sts.idx_last_peer = (idx_r == last_peer[ID_W-1:0]);
    sts.idx_bit       = deferred_r[idx_r];
    sts.mask_last     = ((deferred_r & ~idx_onehot) == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r    <= '0;
      node_count_r <= CNT_RESET;
      requesting_r <= 1'b0;
      replies_r    <= '0;
      highest_r    <= '0;
      own_r        <= '0;
      deferred_r   <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NODE_ID:    node_id_r    <= cfg_data[ID_W-1:0];
          REG_NODE_COUNT: node_count_r <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start_req) begin
        requesting_r <= 1'b1;
        own_r        <= own_nxt;
        replies_r    <= n_peers[ID_W-1:0];
        idx_r        <= '0;
      end
      if (cmd.start_rel) begin
        requesting_r <= 1'b0;
        idx_r        <= '0;
      end
      if (cmd.upd_high && (seq_r > highest_r)) begin
        highest_r <= seq_r;
      end
      if (cmd.set_defer) begin
        deferred_r <= deferred_r | peer_onehot;
      end
      if (cmd.clr_bit) begin
        deferred_r <= deferred_r & ~idx_onehot;
      end
      if (cmd.dec_reply) begin
        replies_r <= replies_r - ID_W'(1);
      end
      if (cmd.idx_inc) begin
        idx_r <= idx_r + ID_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      op_r   <= op_t'(in_operation);
      peer_r <= in_peer_id;
      seq_r  <= in_sequence_req;
    end
    if (cmd.emit) begin
      kind_r <= cmd.emit_kind;
      dest_r <= dest_nxt;
      seqo_r <= (cmd.emit_kind == MSG_REQUEST) ? own_r : '0;
      last_r <= cmd.emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_message_kind = kind_r;
  assign out_dest_node    = dest_r;
  assign out_sequence_out = seqo_r;
  assign out_last         = last_r;

endmodule

[rtl/core/ramutex_ctrl.sv]
// Controller FSM: decodes each event, steps the peer scan and issues emits.
// Depends on ramutex_pkg and ricart_agrawala_mutex_node_defines.svh.
`include "ricart_agrawala_mutex_node_defines.svh"
module ramutex_ctrl import ramutex_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.emit_kind = MSG_REPLY;
    cmd.emit_dest = DEST_IDX;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        unique case (sts.op)
          OP_OWN_REQ: begin
            if (sts.req_idle) begin
              cmd.start_req = 1'b1;
              state_nxt     = S_BCAST;
            end
          end
          OP_OWN_REL: begin
            if (sts.rel_ok) begin
              cmd.start_rel = 1'b1;
              if (sts.mask_any) begin
                state_nxt = S_RELEASE;
              end
            end
          end
          OP_PEER_REQ: begin
            if (sts.peer_ok) begin
              cmd.upd_high = 1'b1;
              if (sts.defer) begin
                cmd.set_defer = 1'b1;
              end else begin
                state_nxt = S_REPLY;
              end
            end
          end
          OP_PEER_REP: begin
            if (sts.reply_ok) begin
              cmd.dec_reply = 1'b1;
              if (sts.reply_final) begin
                state_nxt = S_GRANT;
              end
            end
          end
          default: ;
        endcase
      end
      S_BCAST: begin
        if (sts.idx_is_self) begin
          cmd.idx_inc = 1'b1;
        end else if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = MSG_REQUEST;
          cmd.emit_dest = DEST_IDX;
          cmd.emit_last = sts.idx_last_peer;
          if (sts.idx_last_peer) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_RELEASE: begin
        if (!sts.idx_bit) begin
          cmd.idx_inc = 1'b1;
        end else if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = MSG_REPLY;
          cmd.emit_dest = DEST_IDX;
          cmd.emit_last = sts.mask_last;
          cmd.clr_bit   = 1'b1;
          if (sts.mask_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_REPLY: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = MSG_REPLY;
          cmd.emit_dest = DEST_PEER;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_GRANT: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = MSG_GRANT;
          cmd.emit_dest = DEST_SELF;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `RAMUTEX_ASSERT(a_emit_slot_free, cmd.emit |-> sts.slot_free, "emit while output register busy")
  `RAMUTEX_ASSERT(a_last_ends_item, (cmd.emit && cmd.emit_last) |=> (state_r == S_IDLE), "final message did not end the transaction")
  `RAMUTEX_NEVER(a_bcast_requesting, (state_r == S_BCAST) && sts.req_idle, "broadcast without requesting set")
  `RAMUTEX_ASSERT(a_release_has_work, (state_r == S_RELEASE) |-> sts.mask_any, "release scan with empty deferred set")

endmodule

[rtl/core/ricart_agrawala_mutex_node.sv]
// Ricart-Agrawala mutual exclusion node, one event transaction at a time.
// Steps: the event is captured, then decided, then the scan visits one node index at a
// time, stalling while the output is busy; broadcast and release scan up to 16 indices, a reply or grant one.
// A new event is taken only in idle, once the previous one has queued its final message, if any.
// Reset (rst_n, synchronous): node_id 0, node_count 2, all protocol state cleared.
module ricart_agrawala_mutex_node import ramutex_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ramutex_cfg_if.sink   cfg_ch,
  ramutex_in_if.sink    in_ch,
  ramutex_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign cfg_ch.ready = rst_n;
  assign in_ch.ready  = in_ready && rst_n;

  ramutex_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ramutex_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .in_operation     (in_ch.operation),
    .in_peer_id       (in_ch.peer_id),
    .in_sequence_req  (in_ch.sequence_req),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_message_kind (out_ch.message_kind),
    .out_dest_node    (out_ch.dest_node),
    .out_sequence_out (out_ch.sequence_out),
    .out_last         (out_ch.last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
